FILE: design/wbps_pkg.sv
// shared types and constants for the wildcard byte pattern scan
package wbps_pkg;

    // fixed field and register widths
    localparam int ADDR_W                = 64;
    localparam int CFG_DATA_W            = 64;
    localparam int PADDR_W               = 5;
    localparam int LEN_W                 = 5;
    localparam int MASK_W                = 16;
    localparam int CFG_PATTERN_BYTES     = 16;
    localparam int MAX_PATTERN_BYTES_DEF = 16;

    // configuration register map, one 8-byte slot each
    typedef enum logic [1:0] {
        REG_PATTERN_LOW,
        REG_PATTERN_HIGH,
        REG_WILDCARD_MASK,
        REG_PATTERN_LENGTH
    } reg_index_t;

    // input beat
    typedef struct packed {
        logic [7:0]        data_byte;
        logic [ADDR_W-1:0] byte_address;
        logic              first_byte;
        logic              last_byte;
    } in_beat_t;

    // result beat
    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] match_address;
    } out_beat_t;

    // configuration seen by the compare logic
    typedef struct packed {
        logic [CFG_DATA_W-1:0] pattern_bytes_low;
        logic [CFG_DATA_W-1:0] pattern_bytes_high;
        logic [MASK_W-1:0]     wildcard_mask;
        logic [LEN_W-1:0]      pattern_length;
    } scan_cfg_t;

endpackage

FILE: design/wbps_regs.sv
// apb configuration registers for the pattern scan
module wbps_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [wbps_pkg::PADDR_W-1:0]    paddr,
    input  logic [wbps_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [wbps_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready,
    output wbps_pkg::scan_cfg_t             cfg
);
    import wbps_pkg::*;

    logic [CFG_DATA_W-1:0] pattern_low_reg;
    logic [CFG_DATA_W-1:0] pattern_high_reg;
    logic [MASK_W-1:0]     wildcard_mask_reg;
    logic [LEN_W-1:0]      pattern_length_reg;
    reg_index_t            reg_idx;
    logic                  wr_en;

    // register select from the 8-byte aligned address
    assign reg_idx = reg_index_t'(paddr[PADDR_W-1:3]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            wildcard_mask_reg  <= '0;
            pattern_length_reg <= LEN_W'(1);
        end else if (wr_en) begin
            case (reg_idx)
                REG_PATTERN_LOW:    pattern_low_reg    <= pwdata;
                REG_PATTERN_HIGH:   pattern_high_reg   <= pwdata;
                REG_WILDCARD_MASK:  wildcard_mask_reg  <= pwdata[MASK_W-1:0];
                REG_PATTERN_LENGTH: pattern_length_reg <= pwdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        case (reg_idx)
            REG_PATTERN_LOW:    prdata = pattern_low_reg;
            REG_PATTERN_HIGH:   prdata = pattern_high_reg;
            REG_WILDCARD_MASK:  prdata = CFG_DATA_W'(wildcard_mask_reg);
            REG_PATTERN_LENGTH: prdata = CFG_DATA_W'(pattern_length_reg);
            default:            prdata = '0;
        endcase
    end

    assign cfg.pattern_bytes_low  = pattern_low_reg;
    assign cfg.pattern_bytes_high = pattern_high_reg;
    assign cfg.wildcard_mask      = wildcard_mask_reg;
    assign cfg.pattern_length     = pattern_length_reg;

endmodule

FILE: design/wbps_match.sv
// byte window, parallel wildcard compare and search state
module wbps_match #(
    parameter int MAX_PATTERN_BYTES = wbps_pkg::MAX_PATTERN_BYTES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  wbps_pkg::scan_cfg_t cfg,
    input  wbps_pkg::in_beat_t  beat,
    input  logic                step,
    output logic                res_valid,
    output wbps_pkg::out_beat_t res
);
    import wbps_pkg::*;

    localparam int FILL_W = $clog2(MAX_PATTERN_BYTES + 1);
    localparam int IDX_W  = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(MAX_PATTERN_BYTES);

    logic [7:0]                   win_reg  [MAX_PATTERN_BYTES];
    logic [7:0]                   win_next [MAX_PATTERN_BYTES];
    logic [FILL_W-1:0]            fill_reg;
    logic [FILL_W-1:0]            fill_next;
    logic                         done_reg;
    logic                         done_next;
    logic [FILL_W-1:0]            base_fill;
    logic [FILL_W-1:0]            len;
    logic                         active;
    logic                         match;
    logic [MAX_PATTERN_BYTES-1:0] slot_ok;
    logic [MAX_PATTERN_BYTES*8-1:0] pat_vec;
    logic [MAX_PATTERN_BYTES-1:0]   wild_vec;
    logic [CFG_PATTERN_BYTES*8-1:0] cfg_pat;

    assign cfg_pat = {cfg.pattern_bytes_high, cfg.pattern_bytes_low};

    // pattern bytes past the configured sixteen are zero and never wild
    for (genvar gi = 0; gi < MAX_PATTERN_BYTES; gi++) begin : g_pat
        if (gi < CFG_PATTERN_BYTES) begin : g_cfg
            assign pat_vec[gi*8 +: 8] = cfg_pat[gi*8 +: 8];
            assign wild_vec[gi]       = cfg.wildcard_mask[gi];
        end else begin : g_zero
            assign pat_vec[gi*8 +: 8] = 8'h00;
            assign wild_vec[gi]       = 1'b0;
        end
    end

    // effective length: zero acts as one, clamp at the window depth
    always_comb begin
        if (cfg.pattern_length == '0) begin
            len = FILL_W'(1);
        end else if (int'(cfg.pattern_length) > MAX_PATTERN_BYTES) begin
            len = FILL_MAX;
        end else begin
            len = FILL_W'(cfg.pattern_length);
        end
    end

    // a first byte restarts the search with an empty window
    assign active    = beat.first_byte || !done_reg;
    assign base_fill = beat.first_byte ? '0 : fill_reg;
    assign fill_next = (base_fill == FILL_MAX) ? FILL_MAX : base_fill + FILL_W'(1);

    // shift the new byte into slot zero
    always_comb begin
        win_next[0] = beat.data_byte;
        for (int k = 1; k < MAX_PATTERN_BYTES; k++) begin
            win_next[k] = win_reg[k-1];
        end
    end

    // slot s holds pattern byte len-1-s; slots past the length always pass
    always_comb begin
        logic [FILL_W-1:0] slot_idx;
        logic [IDX_W-1:0]  pidx;
        for (int s = 0; s < MAX_PATTERN_BYTES; s++) begin
            slot_idx   = len - FILL_W'(1) - FILL_W'(s);
            pidx       = slot_idx[IDX_W-1:0];
            slot_ok[s] = (FILL_W'(s) >= len) || wild_vec[pidx]
                         || (win_next[s] == pat_vec[pidx*8 +: 8]);
        end
    end

    assign match     = active && (fill_next >= len) && (&slot_ok);
    assign res_valid = active && (match || beat.last_byte);
    assign done_next = res_valid;

    // result: start address of the match, or not found at region end
    assign res.found         = match;
    assign res.match_address = match ? beat.byte_address - ADDR_W'(len - FILL_W'(1))
                                     : '0;

    // search control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            done_reg <= 1'b0;
        end else if (step && active) begin
            fill_reg <= fill_next;
            done_reg <= done_next;
        end
    end

    // window bytes, qualified by the fill count
    always_ff @(posedge aclk) begin
        if (step && active) begin
            win_reg <= win_next;
        end
    end

endmodule

FILE: design/wildcard_byte_pattern_scan.sv
// top level of the wildcard byte pattern scan
// each input beat is registered in the input stage, compared, and its result beat registered in the output stage
// throughput: one input beat per cycle while the result side is not stalled, set by the window compare stage
// a stalled result holds the output register, so the input takes a beat only while its register is empty, then stalls
// reset (aresetn low, synchronous) empties the pipeline, window and done mark,
// and returns the registers to zero with pattern length one
module wildcard_byte_pattern_scan #(
    parameter int MAX_PATTERN_BYTES = wbps_pkg::MAX_PATTERN_BYTES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [wbps_pkg::PADDR_W-1:0]    paddr,
    input  logic [wbps_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [wbps_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  wbps_pkg::in_beat_t              s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output wbps_pkg::out_beat_t             m_data
);
    import wbps_pkg::*;

    scan_cfg_t cfg;
    in_beat_t  in_beat_reg;
    logic      in_valid_reg;
    out_beat_t out_beat_reg;
    logic      out_valid_reg;
    out_beat_t res;
    logic      res_valid;
    logic      advance;
    logic      step;

    // configuration registers
    wbps_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // compare stage
    wbps_match #(
        .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
    ) u_match (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .beat      (in_beat_reg),
        .step      (step),
        .res_valid (res_valid),
        .res       (res)
    );

    // pipeline flow: the input stage moves whenever the output slot frees up
    assign advance = !out_valid_reg || m_ready;
    assign step    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    // stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= step && res_valid;
            end
        end
    end

    // stage payloads
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_beat_reg <= s_data;
        end
        if (step && res_valid) begin
            out_beat_reg <= res;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_beat_reg;

endmodule

FILE: design/wbps_checker.sv
// port-level checks for the pattern scan, bound to the top level
module wbps_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input wbps_pkg::out_beat_t m_data
);
    import wbps_pkg::*;

    // reset leaves no result pending and the input side open
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid && s_ready))
        else $error("result pending or input blocked after reset");

    // a stalled result beat holds
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result beat changed while stalled");

    // a not-found result carries address zero
    a_notfound_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.found) |-> (m_data.match_address == '0))
        else $error("not-found result with nonzero address");

    // an empty output register never backs up the input
    a_input_open: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output register");

endmodule

bind wildcard_byte_pattern_scan wbps_checker u_wbps_checker (.*);

FILE: tb/testbench.sv
// self-checking testbench for the wildcard byte pattern scan
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import wbps_pkg::*;

    localparam int          DEPTH      = MAX_PATTERN_BYTES_DEF;
    localparam int          PERIOD     = 10;
    localparam int unsigned ITEM_BEATS = 1800;
    localparam int unsigned CYCLE_CAP  = 200000;
    localparam int unsigned HOLD_LEN   = 400;

    // one line of the directed plan: a register write or an input beat
    typedef struct {
        bit          is_cfg;
        reg_index_t  cfg_reg;
        logic [63:0] cfg_value;
        in_beat_t    beat;
        bit          typed;
        bit          typed_hit;
        out_beat_t   typed_result;
    } scan_row_t;

    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [PADDR_W-1:0]    paddr   = '0;
    logic [CFG_DATA_W-1:0] pwdata  = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_beat_t              s_data  = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_beat_t             m_data;

    // predictor copy of the registers and the search state
    logic [63:0]   cfg_lo   = '0;
    logic [63:0]   cfg_hi   = '0;
    logic [15:0]   cfg_mask = '0;
    logic [4:0]    cfg_len  = 5'd1;
    logic [7:0]    win [DEPTH];
    int unsigned   fill     = 0;
    bit            done     = 1'b0;

    out_beat_t     pending_results [$];
    scan_row_t     plan [$];
    int unsigned   beats_in  = 0;
    int unsigned   cycles    = 0;
    int unsigned   fails     = 0;
    int unsigned   hold_left = 0;
    bit            hold_used = 1'b0;

    wildcard_byte_pattern_scan DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #(PERIOD / 2) aclk = ~aclk;

    // run-time guard
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // stretch of beats with no idling on either side
    function automatic bit calm_phase();
        return beats_in >= 700 && beats_in < 1000;
    endfunction

    function automatic int unsigned eff_len();
        if (cfg_len < 5'd1)
            return 1;
        if (cfg_len > 5'(DEPTH))
            return DEPTH;
        return int'(cfg_len);
    endfunction

    function automatic logic [7:0] pat_byte(input int unsigned i);
        if (i < 8)
            return cfg_lo[8*i +: 8];
        return cfg_hi[8*(i-8) +: 8];
    endfunction

    // window compare on one beat, updates the search state
    function automatic void scan_predict(input in_beat_t b, output out_beat_t r,
                                         output bit hit);
        int unsigned len;
        bit          match;
        r = '0;
        hit = 1'b0;
        if (b.first_byte) begin
            foreach (win[k]) win[k] = 8'h00;
            fill = 0;
            done = 1'b0;
        end
        if (done)
            return;
        for (int k = DEPTH - 1; k > 0; k--) win[k] = win[k-1];
        win[0] = b.data_byte;
        if (fill < DEPTH)
            fill++;
        len = eff_len();
        match = fill >= len;
        for (int i = 0; i < len; i++) begin
            if (!cfg_mask[i] && win[len-1-i] != pat_byte(i))
                match = 1'b0;
        end
        if (match) begin
            hit = 1'b1;
            r.found = 1'b1;
            r.match_address = b.byte_address - 64'(len - 1);
            done = 1'b1;
        end else if (b.last_byte) begin
            hit = 1'b1;
            done = 1'b1;
        end
    endfunction

    function automatic void add_cfg(input reg_index_t idx, input logic [63:0] value);
        scan_row_t row;
        row.is_cfg = 1'b1;
        row.cfg_reg = idx;
        row.cfg_value = value;
        row.beat = '0;
        row.typed = 1'b0;
        row.typed_hit = 1'b0;
        row.typed_result = '0;
        plan.push_back(row);
    endfunction

    function automatic void add_beat(input logic [7:0] data, input logic [63:0] addr,
                                     input bit first, input bit last, input bit typed = 0,
                                     input bit hit = 0, input bit found = 0,
                                     input logic [63:0] maddr = '0);
        scan_row_t row;
        row.is_cfg = 1'b0;
        row.cfg_reg = REG_PATTERN_LOW;
        row.cfg_value = '0;
        row.beat = '{data_byte: data, byte_address: addr, first_byte: first,
                     last_byte: last};
        row.typed = typed;
        row.typed_hit = hit;
        row.typed_result = '{found: found, match_address: maddr};
        plan.push_back(row);
    endfunction

    // offer one beat, wait for the handshake, record what it should cause
    task automatic push_beat(input in_beat_t b, input bit typed, input bit typed_hit,
                             input out_beat_t typed_res);
        out_beat_t r;
        bit        hit;
        while (!calm_phase() && $urandom_range(99) < 15) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        do @(posedge aclk); while (!s_ready);
        beats_in++;
        scan_predict(b, r, hit);
        if (typed) begin
            hit = typed_hit;
            r = typed_res;
        end
        if (hit)
            pending_results.push_back(r);
        @(negedge aclk);
    endtask

    // drain everything in flight before touching the registers
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // apb write then read back
    task automatic apb_write(input reg_index_t idx, input logic [63:0] value);
        logic [63:0] rd;
        logic [63:0] want;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            REG_PATTERN_LOW:    begin cfg_lo = value;        want = value; end
            REG_PATTERN_HIGH:   begin cfg_hi = value;        want = value; end
            REG_WILDCARD_MASK:  begin cfg_mask = value[15:0]; want = 64'(value[15:0]); end
            default:            begin cfg_len = value[4:0];  want = 64'(value[4:0]); end
        endcase
        @(negedge aclk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rd = prdata;
        if (rd !== want) begin
            $error("register %s: expected %h, got %h", idx.name(), want, rd);
            fails++;
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // new register setting, extremes included
    task automatic shuffle_config();
        logic [15:0] mk;
        logic [4:0]  ln;
        case ($urandom_range(3))
            0:       mk = 16'h0000;
            1:       mk = 16'hFFFF;
            2:       mk = 16'($urandom);
            default: mk = 16'($urandom) & 16'($urandom) & 16'($urandom);
        endcase
        case ($urandom_range(5))
            0:       ln = 5'd0;
            1:       ln = 5'd1;
            2:       ln = 5'd16;
            3:       ln = 5'd31;
            default: ln = 5'($urandom_range(16, 1));
        endcase
        settle();
        apb_write(REG_PATTERN_LOW, {$urandom, $urandom});
        apb_write(REG_PATTERN_HIGH, {$urandom, $urandom});
        apb_write(REG_WILDCARD_MASK, 64'(mk));
        apb_write(REG_PATTERN_LENGTH, 64'(ln));
    endtask

    // one scanned region, mostly well formed, sometimes with the pattern planted
    task automatic scan_region();
        int unsigned n;
        int unsigned len;
        int unsigned plant_at;
        logic [63:0] base;
        bit          plant;
        bit          broken;
        in_beat_t    b;
        len = eff_len();
        n = ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(24, 1);
        plant = (n >= len) && $urandom_range(1);
        plant_at = plant ? $urandom_range(n - len, 0) : 0;
        case ($urandom_range(9))
            0:       base = 64'h0 - 64'($urandom_range(30));
            1:       base = 64'h0;
            default: base = {$urandom, $urandom};
        endcase
        broken = $urandom_range(9) == 0;
        for (int j = 0; j < n; j++) begin
            if (plant && j >= plant_at && j < plant_at + len && !cfg_mask[j - plant_at])
                b.data_byte = pat_byte(j - plant_at);
            else if ($urandom_range(1))
                b.data_byte = pat_byte($urandom_range(len - 1));
            else
                b.data_byte = 8'($urandom);
            if (broken) begin
                b.first_byte = ($urandom_range(7) == 0);
                b.last_byte = ($urandom_range(7) == 0);
                b.byte_address = $urandom_range(1) ? {$urandom, $urandom} : base + 64'(j);
            end else begin
                b.first_byte = (j == 0);
                b.last_byte = (j == n - 1);
                b.byte_address = base + 64'(j);
            end
            push_beat(b, 1'b0, 1'b0, '0);
        end
    endtask

    // result side ready, with one long hold-off once the stream is busy
    always @(negedge aclk) begin
        if (beats_in >= 1300 && !hold_used) begin
            hold_used <= 1'b1;
            hold_left <= HOLD_LEN;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (calm_phase()) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= 15);
        end
    end

    // compare each result beat with the oldest expectation
    always @(posedge aclk) begin
        out_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result beat: found %0d, match_address %h",
                       m_data.found, m_data.match_address);
                fails++;
            end else begin
                want = pending_results.pop_front();
                if (m_data.found !== want.found) begin
                    $error("found: expected %0d, got %0d", want.found, m_data.found);
                    fails++;
                end
                if (m_data.match_address !== want.match_address) begin
                    $error("match_address: expected %h, got %h",
                           want.match_address, m_data.match_address);
                    fails++;
                end
            end
        end
    end

    initial begin
        int unsigned next_cfg;
        logic [7:0]  dir_byte;
        foreach (win[k]) win[k] = 8'h00;

        // reset registers: pattern byte 0 is zero, length one
        add_beat(8'h5A, 64'd100, 0, 0, 1, 0);                  // no first byte after reset
        add_beat(8'h00, 64'd0, 0, 0, 1, 1, 1, 64'd0);          // match at address zero
        add_beat(8'h00, 64'd5, 0, 0, 1, 0);                    // ignored after a result
        add_beat(8'hFF, '1, 1, 1, 1, 1, 0, 64'd0);             // one-byte region, no match
        add_beat(8'h00, '1, 1, 1, 1, 1, 1, '1);                // one-byte region, match
        // full-length pattern with a wildcard, length above the maximum
        add_cfg(REG_PATTERN_LOW, 64'h8877665544332211);
        add_cfg(REG_PATTERN_HIGH, 64'hFFEEDDCCBBAA9900);
        add_cfg(REG_WILDCARD_MASK, 64'h0100);
        add_cfg(REG_PATTERN_LENGTH, 64'd31);
        add_beat(8'h11, 64'd999, 1, 0);                        // false start before the match
        for (int i = 0; i < 15; i++) begin
            if (i == 8)
                dir_byte = 8'h5C;
            else if (i < 8)
                dir_byte = 8'(8'h11 * (i + 1));
            else
                dir_byte = 8'(8'h99 + 8'h11 * (i - 9));
            add_beat(dir_byte, 64'd1000 + 64'(i), 0, 0);
        end
        add_beat(8'hFF, 64'd1015, 0, 1, 1, 1, 1, 64'd1000);    // match on the last byte
        // length zero acts as one
        add_cfg(REG_PATTERN_LENGTH, 64'd0);
        add_beat(8'h11, 64'd7, 1, 0, 1, 1, 1, 64'd7);

        // reset
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed plan
        foreach (plan[p]) begin
            if (plan[p].is_cfg) begin
                settle();
                apb_write(plan[p].cfg_reg, plan[p].cfg_value);
            end else begin
                push_beat(plan[p].beat, plan[p].typed, plan[p].typed_hit,
                          plan[p].typed_result);
            end
        end

        // random regions with a new setting every few hundred beats
        next_cfg = 0;
        while (beats_in < ITEM_BEATS) begin
            if (beats_in >= next_cfg) begin
                shuffle_config();
                next_cfg = beats_in + 300;
            end
            scan_region();
        end

        // drain and let any stray beat show up
        settle();
        repeat (10) @(posedge aclk);
        if (fails == 0 && pending_results.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
